// ===== hw/rtl/obb_pkg.sv =====
// Shared widths and vector types for the oriented box overlap pipeline.
// No dependencies; every module under hw/rtl imports it.
package obb_pkg;

  localparam int CW     = 16;                 // coordinate / extent width, 8 fraction bits
  localparam int AW     = 16;                 // axis component width, Q1.14
  localparam int SH     = 14;                 // axis scale shift
  localparam int LW     = 2 * AW;             // test axis component width
  localparam int TW     = CW + 1;             // center difference width
  localparam int PW     = AW + LW + 2;        // box axis projection width
  localparam int TPW    = TW + LW + 2;        // center projection width
  localparam int SW     = PW + CW + 3;        // projection sum / compare width
  localparam int DW     = 2 * CW + 4;         // squared distance width
  localparam int NBOX   = 6;                  // box axes, A then B
  localparam int NAXES  = 15;                 // six box axes plus nine cross products

  typedef logic [2:0][AW-1:0]      axvec_t;
  typedef logic [2:0][TW-1:0]      tvec_t;
  typedef logic [2:0][LW-1:0]      lvec_t;
  typedef axvec_t [NBOX-1:0]       axset_t;
  typedef logic [NBOX-1:0][CW-1:0] extset_t;
  typedef lvec_t [NAXES-1:0]       lset_t;

endpackage

// ===== hw/rtl/obb_prep.sv =====
// First pipeline stage: unpack both boxes, form T, extent magnitudes, all 15 test axes
// and the squared terms of the early reject. Depends on obb_pkg.
module obb_prep import obb_pkg::*; (
  input  logic             clk_i,
  input  logic [47:0]      center_a_i,
  input  logic [47:0]      axis_a0_i,
  input  logic [47:0]      axis_a1_i,
  input  logic [47:0]      axis_a2_i,
  input  logic [47:0]      extent_a_i,
  input  logic [47:0]      center_b_i,
  input  logic [47:0]      axis_b0_i,
  input  logic [47:0]      axis_b1_i,
  input  logic [47:0]      axis_b2_i,
  input  logic [47:0]      extent_b_i,
  output tvec_t            t_o,
  output axset_t           ax_o,
  output extset_t          ext_o,
  output lset_t            l_o,
  output logic [DW-1:0]    dist2_o,
  output logic [DW-1:0]    lim_o
);

  tvec_t                t_d, t_q;
  axset_t               ax_d, ax_q;
  extset_t              ext_d, ext_q;
  lset_t                l_d, l_q;
  logic [DW-1:0]        dist2_d, dist2_q, lim_d, lim_q;

  always_comb begin
    logic signed [CW-1:0]   ca, cb, ea, eb;
    logic signed [LW-1:0]   p1, p2;
    logic signed [DW-1:0]   tsq;
    logic        [DW-1:0]   esq;
    ax_d[0] = axis_a0_i;
    ax_d[1] = axis_a1_i;
    ax_d[2] = axis_a2_i;
    ax_d[3] = axis_b0_i;
    ax_d[4] = axis_b1_i;
    ax_d[5] = axis_b2_i;
    tsq = '0;
    esq = '0;
    for (int k = 0; k < 3; k++) begin
      ca = $signed(center_a_i[k*CW +: CW]);
      cb = $signed(center_b_i[k*CW +: CW]);
      ea = $signed(extent_a_i[k*CW +: CW]);
      eb = $signed(extent_b_i[k*CW +: CW]);
      t_d[k] = TW'({ca[CW-1], ca} - {cb[CW-1], cb});
      ext_d[k]     = ea[CW-1] ? CW'(~ea + 1'b1) : CW'(ea);
      ext_d[k + 3] = eb[CW-1] ? CW'(~eb + 1'b1) : CW'(eb);
      tsq = tsq + $signed(t_d[k]) * $signed(t_d[k]);
      esq = esq + ext_d[k] * ext_d[k];
    end
    dist2_d = DW'(tsq);
    lim_d   = DW'({esq, 2'b00});
    // box axes scaled into the test axis format
    for (int i = 0; i < NBOX; i++) begin
      for (int k = 0; k < 3; k++) begin
        l_d[i][k] = {{(LW-AW-SH){ax_d[i][k][AW-1]}}, ax_d[i][k], {SH{1'b0}}};
      end
    end
    // cross products A_i x B_j
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          p1 = $signed(ax_d[i][(k+1)%3]) * $signed(ax_d[j+3][(k+2)%3]);
          p2 = $signed(ax_d[i][(k+2)%3]) * $signed(ax_d[j+3][(k+1)%3]);
          l_d[NBOX + i*3 + j][k] = LW'(p1 - p2);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= t_d;
    ax_q    <= ax_d;
    ext_q   <= ext_d;
    l_q     <= l_d;
    dist2_q <= dist2_d;
    lim_q   <= lim_d;
  end

  assign t_o     = t_q;
  assign ax_o    = ax_q;
  assign ext_o   = ext_q;
  assign l_o     = l_q;
  assign dist2_o = dist2_q;
  assign lim_o   = lim_q;

endmodule

// ===== hw/rtl/obb_axis_test.sv =====
// Four-stage separation test on one axis: projections, extent products, pair sums, compare.
// Depends on obb_pkg.
module obb_axis_test import obb_pkg::*; (
  input  logic    clk_i,
  input  lvec_t   l_i,
  input  tvec_t   t_i,
  input  axset_t  ax_i,
  input  extset_t ext_i,
  output logic    sep_o
);

  logic signed [PW-1:0]  proj_d [NBOX];
  logic signed [PW-1:0]  proj_q [NBOX];
  logic signed [TPW-1:0] tproj_d, tproj_q;
  logic [SW-1:0]         term_d [NBOX];
  logic [SW-1:0]         term_q [NBOX];
  logic [SW-1:0]         lhs_d, lhs_q, lhs2_q;
  logic [SW-1:0]         pair_d [3];
  logic [SW-1:0]         pair_q [3];
  logic                  sep_d, sep_q;
  extset_t               ext_s2_q;

  // stage 2: dot products
  always_comb begin
    logic signed [AW+LW-1:0] pa;
    logic signed [TW+LW-1:0] pt;
    tproj_d = '0;
    for (int i = 0; i < NBOX; i++) begin
      proj_d[i] = '0;
      for (int k = 0; k < 3; k++) begin
        pa = $signed(ax_i[i][k]) * $signed(l_i[k]);
        proj_d[i] = proj_d[i] + pa;
      end
    end
    for (int k = 0; k < 3; k++) begin
      pt = $signed(t_i[k]) * $signed(l_i[k]);
      tproj_d = tproj_d + pt;
    end
  end

  // stage 3: magnitudes times extents
  always_comb begin
    logic [PW-1:0]  pm;
    logic [TPW-1:0] tm;
    for (int i = 0; i < NBOX; i++) begin
      pm = proj_q[i][PW-1] ? PW'(-proj_q[i]) : PW'(proj_q[i]);
      term_d[i] = SW'(pm * ext_s2_q[i]);
    end
    tm = tproj_q[TPW-1] ? TPW'(-tproj_q) : TPW'(tproj_q);
    lhs_d = SW'({tm, {SH{1'b0}}});
  end

  // stage 4: pair sums; stage 5: final sum and strict compare
  always_comb begin
    for (int p = 0; p < 3; p++) begin
      pair_d[p] = term_q[2*p] + term_q[2*p+1];
    end
    sep_d = lhs2_q > (pair_q[0] + pair_q[1] + pair_q[2]);
  end

  always_ff @(posedge clk_i) begin
    proj_q   <= proj_d;
    tproj_q  <= tproj_d;
    ext_s2_q <= ext_i;
    term_q   <= term_d;
    lhs_q    <= lhs_d;
    pair_q   <= pair_d;
    lhs2_q   <= lhs_q;
    sep_q    <= sep_d;
  end

  assign sep_o = sep_q;

endmodule

// ===== hw/rtl/oriented_box_overlap_test.sv =====
// Top level of the oriented box overlap test: prep stage, 15 axis testers, result stage.
// Depends on obb_pkg, obb_prep and obb_axis_test.
//
// Each accepted box pair yields one result, marked by done_o for one cycle; a new pair may
// be started in every cycle, so busy stays low. The pipeline consists of the prep stage
// (unpack, center difference, cross products, reject squares), four stages of the
// per-axis tester (projections, extent products, pair sums, compare) and the
// output register. All fifteen axes are tested side by side, one tester each. far_reject_o
// is set when the squared center distance exceeds four times the squared length of box A's
// half extents; colliding_o is then low. Results cannot be held off: capture them in the
// cycle done_o is high.
module oriented_box_overlap_test import obb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [47:0] center_a_i,
  input  logic [47:0] axis_a0_i,
  input  logic [47:0] axis_a1_i,
  input  logic [47:0] axis_a2_i,
  input  logic [47:0] extent_a_i,
  input  logic [47:0] center_b_i,
  input  logic [47:0] axis_b0_i,
  input  logic [47:0] axis_b1_i,
  input  logic [47:0] axis_b2_i,
  input  logic [47:0] extent_b_i,
  output logic        done_o,
  output logic        colliding_o,
  output logic        far_reject_o
);

  tvec_t            t_s1;
  axset_t           ax_s1;
  extset_t          ext_s1;
  lset_t            l_s1;
  logic [DW-1:0]    dist2_s1, lim_s1;
  logic [NAXES-1:0] sep_s5;

  logic [4:0] vld_q;           // valid of stages one to five
  logic       far_d;
  logic [3:0] far_q;           // reject flag, stages two to five
  logic       done_q, coll_q, far_out_q;

  // the pipeline never stalls
  assign busy = 1'b0;

  obb_prep u_prep (
    .clk_i      (clk_i),
    .center_a_i (center_a_i),
    .axis_a0_i  (axis_a0_i),
    .axis_a1_i  (axis_a1_i),
    .axis_a2_i  (axis_a2_i),
    .extent_a_i (extent_a_i),
    .center_b_i (center_b_i),
    .axis_b0_i  (axis_b0_i),
    .axis_b1_i  (axis_b1_i),
    .axis_b2_i  (axis_b2_i),
    .extent_b_i (extent_b_i),
    .t_o        (t_s1),
    .ax_o       (ax_s1),
    .ext_o      (ext_s1),
    .l_o        (l_s1),
    .dist2_o    (dist2_s1),
    .lim_o      (lim_s1)
  );

  for (genvar g = 0; g < NAXES; g++) begin : g_axis
    obb_axis_test u_axis (
      .clk_i (clk_i),
      .l_i   (l_s1[g]),
      .t_i   (t_s1),
      .ax_i  (ax_s1),
      .ext_i (ext_s1),
      .sep_o (sep_s5[g])
    );
  end

  // early reject compare, aligned with the axis projections
  assign far_d = dist2_s1 > lim_s1;

  always_ff @(posedge clk_i) begin
    far_q <= {far_q[2:0], far_d};
  end

  // advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      done_q    <= 1'b0;
      coll_q    <= 1'b0;
      far_out_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[3:0], start & ~busy};
      done_q    <= vld_q[4];
      coll_q    <= vld_q[4] & ~far_q[3] & ~|sep_s5;
      far_out_q <= vld_q[4] & far_q[3];
    end
  end

  assign done_o       = done_q;
  assign colliding_o  = coll_q;
  assign far_reject_o = far_out_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start & ~busy |-> ##6 done_o)
    else $error("transfer did not produce a result after six cycles");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(colliding_o && far_reject_o))
    else $error("colliding and far reject both set");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !colliding_o && !far_reject_o)
    else $error("result flags set without a transfer");

endmodule

// ===== test/tb.sv =====
// Self-checking bench for oriented_box_overlap_test: directed box pairs, then random ones.
// Depends on obb_pkg and the RTL under hw/rtl; needs no files or arguments.
`timescale 1ns / 100ps

module tb;
  import obb_pkg::*;

  localparam int NUM_RANDOM  = 1500;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 12;      // idle margin after the last result

  typedef struct {
    logic [47:0] f [10];   // center_a, axis_a0..2, extent_a, center_b, axis_b0..2, extent_b
    bit          known;    // expected outcome typed in below
    bit          coll;
    bit          far;
  } pair_row_t;

  typedef struct {
    bit coll;
    bit far;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [47:0] box_in [10];
  logic        done, colliding, far_reject;
  bit          row_known = 1'b0;
  bit          row_coll = 1'b0;
  bit          row_far = 1'b0;

  verdict_t    verdict_q [$];
  int          mismatches = 0;
  int          cycles = 0;
  int          n_sent = 0;
  int          n_coll = 0;
  int          n_far = 0;
  int          n_sep = 0;
  pair_row_t   dir_rows [$];

  always #2 clk = ~clk;

  oriented_box_overlap_test u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .center_a_i  (box_in[0]),
    .axis_a0_i   (box_in[1]),
    .axis_a1_i   (box_in[2]),
    .axis_a2_i   (box_in[3]),
    .extent_a_i  (box_in[4]),
    .center_b_i  (box_in[5]),
    .axis_b0_i   (box_in[6]),
    .axis_b1_i   (box_in[7]),
    .axis_b2_i   (box_in[8]),
    .extent_b_i  (box_in[9]),
    .done_o      (done),
    .colliding_o (colliding),
    .far_reject_o(far_reject)
  );

  // Pack three signed 16-bit components, x in the low bits.
  function automatic logic [47:0] pk(input int x, input int y, input int z);
    logic [15:0] a, b, c;
    a = x[15:0];
    b = y[15:0];
    c = z[15:0];
    return {c, b, a};
  endfunction

  function automatic longint comp(input logic [47:0] v, input int k);
    logic signed [15:0] s;
    s = v[16*k +: 16];
    return longint'(s);
  endfunction

  // True when test axis l (28 fraction bits) splits the two boxes.
  function automatic bit splits_on(input longint t[3], input longint l[3],
                                   input longint ax[6][3], input longint ext[6]);
    logic [127:0] proj_sum, center_proj;
    longint d;
    proj_sum = '0;
    for (int i = 0; i < 6; i++) begin
      d = ax[i][0] * l[0] + ax[i][1] * l[1] + ax[i][2] * l[2];
      if (d < 0) d = -d;
      proj_sum += 128'(d) * 128'(ext[i]);
    end
    d = t[0] * l[0] + t[1] * l[1] + t[2] * l[2];
    if (d < 0) d = -d;
    center_proj = 128'(d) << SH;
    return center_proj > proj_sum;
  endfunction

  function automatic verdict_t overlap_verdict(input logic [47:0] f[10]);
    longint t[3], l[3], ext[6], ax[6][3];
    longint dist2, lim;
    bit split;
    verdict_t v;
    for (int k = 0; k < 3; k++) begin
      t[k] = comp(f[0], k) - comp(f[5], k);
      ext[k] = comp(f[4], k);
      ext[k + 3] = comp(f[9], k);
      if (ext[k] < 0) ext[k] = -ext[k];
      if (ext[k + 3] < 0) ext[k + 3] = -ext[k + 3];
      for (int i = 0; i < 3; i++) begin
        ax[i][k] = comp(f[1 + i], k);
        ax[i + 3][k] = comp(f[6 + i], k);
      end
    end
    dist2 = t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
    lim = 4 * (ext[0] * ext[0] + ext[1] * ext[1] + ext[2] * ext[2]);
    v.far = dist2 > lim;
    v.coll = 1'b0;
    if (v.far) return v;
    split = 1'b0;
    for (int i = 0; i < 6 && !split; i++) begin
      for (int k = 0; k < 3; k++) l[k] = ax[i][k] <<< SH;
      split = splits_on(t, l, ax, ext);
    end
    for (int i = 0; i < 3 && !split; i++)
      for (int j = 3; j < 6 && !split; j++) begin
        l[0] = ax[i][1] * ax[j][2] - ax[i][2] * ax[j][1];
        l[1] = ax[i][2] * ax[j][0] - ax[i][0] * ax[j][2];
        l[2] = ax[i][0] * ax[j][1] - ax[i][1] * ax[j][0];
        split = splits_on(t, l, ax, ext);
      end
    v.coll = !split;
    return v;
  endfunction

  task automatic report(input string what, input bit got, input bit want);
    mismatches++;
    $display("MISMATCH @%0t %s: got %0b, want %0b", $realtime, what, got, want);
  endtask

  // Sample at the edge: values seen here are the ones before this step's updates.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n) begin
      cycles++;
      if (start && !busy) begin
        if (row_known) begin
          v.coll = row_coll;
          v.far = row_far;
        end else begin
          v = overlap_verdict(box_in);
        end
        verdict_q.push_back(v);
      end
      if (done) begin
        if (verdict_q.size() == 0) begin
          report("result with nothing pending", colliding, 1'b0);
        end else begin
          v = verdict_q.pop_front();
          if (colliding !== v.coll) report("colliding", colliding, v.coll);
          if (far_reject !== v.far) report("far_reject", far_reject, v.far);
          if (v.far) n_far++;
          else if (v.coll) n_coll++;
          else n_sep++;
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("oriented_box_overlap_test test failed");
        $finish;
      end
    end
  end

  // Hold the pair on the ports until a transfer happens; drop start only for a gap.
  task automatic send_pair(input pair_row_t r);
    int gap;
    gap = $urandom_range(0, 11);
    if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;   // stretches of back-to-back
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    box_in    <= r.f;
    row_known <= r.known;
    row_coll  <= r.coll;
    row_far   <= r.far;
    do @(posedge clk); while (busy);
    n_sent++;
  endtask

  function automatic pair_row_t mk_row(input logic [47:0] ca, a0, a1, a2, ea,
                                       input logic [47:0] cb, b0, b1, b2, eb,
                                       input bit known = 0, coll = 0, far = 0);
    pair_row_t r;
    r.f = '{ca, a0, a1, a2, ea, cb, b0, b1, b2, eb};
    r.known = known;
    r.coll = coll;
    r.far = far;
    return r;
  endfunction

  function automatic int jitter(input int c);
    return ($urandom_range(0, 2) == 0) ? c + $urandom_range(0, 4000) - 2000 : c;
  endfunction

  // Signed permutation frame, optionally perturbed so cross axes come into play.
  function automatic void rand_frame(output logic [47:0] a[3]);
    int p, s[3], c[3][3];
    p = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) begin
      s[i] = $urandom_range(0, 1) ? 16384 : -16384;
      for (int k = 0; k < 3; k++) c[i][k] = 0;
      c[i][(i + p) % 3] = s[i];
    end
    for (int i = 0; i < 3; i++)
      a[i] = pk(jitter(c[i][0]), jitter(c[i][1]), jitter(c[i][2]));
  endfunction

  function automatic pair_row_t rand_row();
    pair_row_t r;
    logic [47:0] fa[3], fb[3];
    int sp;
    r.known = 0;
    r.coll = 0;
    r.far = 0;
    if ($urandom_range(0, 4) == 0) begin
      // noise: every bit of every field
      for (int i = 0; i < 10; i++) r.f[i] = 48'({$urandom(), $urandom()});
      return r;
    end
    rand_frame(fa);
    rand_frame(fb);
    sp = ($urandom_range(0, 7) == 0) ? 32767 : 1024;
    r.f[0] = pk($urandom_range(0, 2 * sp) - sp, $urandom_range(0, 2 * sp) - sp,
                $urandom_range(0, 2 * sp) - sp);
    r.f[5] = pk($urandom_range(0, 2 * sp) - sp, $urandom_range(0, 2 * sp) - sp,
                $urandom_range(0, 2 * sp) - sp);
    r.f[4] = pk($urandom_range(0, 1024) - ($urandom_range(0, 9) == 0 ? 512 : 0),
                $urandom_range(0, 1024), $urandom_range(0, 1024));
    r.f[9] = pk($urandom_range(0, 1024), $urandom_range(0, 1024) -
                ($urandom_range(0, 9) == 0 ? 512 : 0), $urandom_range(0, 1024));
    for (int i = 0; i < 3; i++) begin
      r.f[1 + i] = fa[i];
      r.f[6 + i] = fb[i];
    end
    return r;
  endfunction

  initial begin
    logic [47:0] ex, ey, ez, zero, one;
    for (int i = 0; i < 10; i++) box_in[i] = '0;
    ex = pk(16384, 0, 0);
    ey = pk(0, 16384, 0);
    ez = pk(0, 0, 16384);
    zero = '0;
    one = pk(256, 256, 256);

    // all zero: no reject, every test axis degenerate, so overlap
    dir_rows.push_back(mk_row(zero, zero, zero, zero, zero, zero, zero, zero, zero, zero,
                              1, 1, 0));
    // coincident unit cubes, parallel frames (degenerate cross axes)
    dir_rows.push_back(mk_row(zero, ex, ey, ez, one, zero, ex, ey, ez, one, 1, 1, 0));
    // centers at opposite coordinate extremes, zero extents: far reject
    dir_rows.push_back(mk_row(pk(32767, 32767, 32767), ex, ey, ez, zero,
                              pk(-32768, -32768, -32768), ex, ey, ez, zero, 1, 0, 1));
    // touching faces: equality does not separate
    dir_rows.push_back(mk_row(zero, ex, ey, ez, one, pk(512, 0, 0), ex, ey, ez, one));
    // just past touching
    dir_rows.push_back(mk_row(zero, ex, ey, ez, one, pk(513, 0, 0), ex, ey, ez, one));
    // negative extents on both boxes
    dir_rows.push_back(mk_row(zero, ex, ey, ez, pk(-256, -256, -256), pk(300, 0, 0),
                              ex, ey, ez, pk(-256, 256, -256)));
    // B rotated 45 degrees about z, separated on face axes and on cross axes
    dir_rows.push_back(mk_row(zero, ex, ey, ez, one, pk(600, 600, 0),
                              pk(11585, 11585, 0), pk(-11585, 11585, 0), ez, pk(256, 16, 256)));
    // edge-edge: rotated about x and about z
    dir_rows.push_back(mk_row(zero, pk(11585, 11585, 0), pk(-11585, 11585, 0), ez, one,
                              pk(0, 400, 400), ex, pk(0, 11585, 11585), pk(0, -11585, 11585),
                              one));
    // non-unit axes at the component extremes
    dir_rows.push_back(mk_row(pk(100, -100, 50), pk(32767, -32768, 32767),
                              pk(-32768, 32767, 0), pk(1, -1, 32767), pk(32767, 32767, 32767),
                              pk(-100, 100, -50), pk(-32768, -32768, -32768),
                              pk(32767, 0, -32768), pk(0, 32767, 1), pk(-32768, 1, 0)));
    // all ones on every field
    dir_rows.push_back(mk_row('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    // largest extents with extreme centers
    dir_rows.push_back(mk_row(pk(32767, -32768, 0), ex, ey, ez, pk(-32768, -32768, -32768),
                              pk(-32768, 32767, 0), ey, ez, ex, pk(32767, 32767, 32767)));
    // reject boundary: |T|^2 = 4*h^2 exactly, not rejected
    dir_rows.push_back(mk_row(pk(512, 0, 0), ex, ey, ez, pk(256, 0, 0), zero,
                              ex, ey, ez, pk(256, 0, 0)));
    dir_rows.push_back(mk_row(pk(513, 0, 0), ex, ey, ez, pk(256, 0, 0), zero,
                              ex, ey, ez, pk(256, 0, 0), 1, 0, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_pair(dir_rows[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        // pause the sender until the pipeline has emptied
        start <= 1'b0;
        do @(posedge clk); while (verdict_q.size() != 0);
      end
      send_pair(rand_row());
    end
    start <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d box pairs: %0d overlapping, %0d separated by an axis, %0d far rejects",
             n_sent, n_coll, n_sep, n_far);
    if (mismatches == 0) begin
      $display("oriented_box_overlap_test test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("oriented_box_overlap_test test failed");
    end
    $finish;
  end
endmodule
